[rtl/fpa_pkg.sv]
// Shared constants, codes and types of the fit policy partition allocator.
// No dependencies.
package fpa_pkg;

	localparam int PARTITIONS = 8;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_W      = 3;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	localparam logic [1:0] ST_LOADED = 2'd0;
	localparam logic [1:0] ST_ALLOC  = 2'd1;
	localparam logic [1:0] ST_NOMEM  = 2'd2;

	// scan token passed cell to cell
	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     pick;
		logic [SIZE_BITS-1:0] key;
		logic [SIZE_BITS-1:0] pick_free;
	} tok_t;

	// write broadcast to the cells
	typedef struct packed {
		logic                 en;
		logic [IDX_W-1:0]     idx;
		logic [SIZE_BITS-1:0] data;
	} wr_t;

endpackage

[rtl/fpa_if.sv]
// Valid/ready channel interfaces: request, response and mode register write.
// Depends on fpa_pkg.
interface fpa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [fpa_pkg::IDX_W-1:0]     part_index;
	logic [fpa_pkg::SIZE_BITS-1:0] size;
	modport source(output valid, operation, part_index, size, input ready);
	modport sink(input valid, operation, part_index, size, output ready);
endinterface

interface fpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [fpa_pkg::IDX_W-1:0]     chosen_index;
	logic [fpa_pkg::SIZE_BITS-1:0] remaining;
	modport source(output valid, status, chosen_index, remaining, input ready);
	modport sink(input valid, status, chosen_index, remaining, output ready);
endinterface

interface fpa_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

[rtl/fit_policy_partition_allocator.sv]
// Fit policy partition allocator: a load transaction sets one partition's
// free size; an allocate transaction is placed by first, best or worst fit
// (ties to the lowest index) and the chosen partition is reduced by the
// request. Each partition lives in a cell of a chain; an allocation sends a
// token down the chain, one cell per cycle. One transaction is in flight at
// a time, and a new one is accepted while the previous result still waits
// in the output register. Mode code 3 acts as first fit.
// Depends on fpa_pkg, fpa_if and fpa_cell.
module fit_policy_partition_allocator (
	input  logic      clk,
	input  logic      arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp,
	fpa_cfg_if.sink   cfg
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	localparam int P = fpa_pkg::PARTITIONS;

	logic [1:0]                    state_q;
	logic [1:0]                    fit_mode_q;
	logic                          launch_q;
	logic [fpa_pkg::IDX_W-1:0]     idx_q;
	logic [fpa_pkg::SIZE_BITS-1:0] size_q;
	fpa_pkg::tok_t                 fin_q;
	logic                          rsp_valid_q;
	logic [1:0]                    status_q;
	logic [fpa_pkg::IDX_W-1:0]     chosen_q;
	logic [fpa_pkg::SIZE_BITS-1:0] remaining_q;

	logic                          slot_free;
	logic [fpa_pkg::SIZE_BITS-1:0] alloc_rem;
	fpa_pkg::wr_t                  wr;
	logic [P:0]                    tok_v;
	fpa_pkg::tok_t                 tok [P+1];

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign alloc_rem = fin_q.pick_free - size_q;

	assign tok_v[0] = launch_q;
	assign tok[0]   = '0;

	for (genvar k = 0; k < P; k++) begin : g_cell
		fpa_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.cell_idx      (fpa_pkg::IDX_W'(k)),
			.fit_mode      (fit_mode_q),
			.req_size      (size_q),
			.wr            (wr),
			.tok_in_valid  (tok_v[k]),
			.tok_in        (tok[k]),
			.tok_out_valid (tok_v[k+1]),
			.tok_out       (tok[k+1])
		);
	end

	always_comb begin
		wr.en   = slot_free && ((state_q == S_LOAD) || (state_q == S_FIN && fin_q.found));
		wr.idx  = (state_q == S_LOAD) ? idx_q : fin_q.pick;
		wr.data = (state_q == S_LOAD) ? size_q : alloc_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fit_mode_q  <= fpa_pkg::MODE_FIRST;
			launch_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			launch_q <= (state_q == S_IDLE) && req.valid &&
				(req.operation == fpa_pkg::OP_ALLOC);
			if (cfg.valid && cfg.ready) begin
				fit_mode_q <= cfg.data;
			end
			if ((state_q == S_LOAD || state_q == S_FIN) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						if (req.operation == fpa_pkg::OP_LOAD) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tok_v[P]) begin
						state_q <= S_FIN;
					end
				end
				S_LOAD, S_FIN: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			idx_q  <= req.part_index;
			size_q <= req.size;
		end
		if (state_q == S_SCAN && tok_v[P]) begin
			fin_q <= tok[P];
		end
		if (slot_free && state_q == S_LOAD) begin
			status_q    <= fpa_pkg::ST_LOADED;
			chosen_q    <= idx_q;
			remaining_q <= size_q;
		end else if (slot_free && state_q == S_FIN) begin
			if (fin_q.found) begin
				status_q    <= fpa_pkg::ST_ALLOC;
				chosen_q    <= fin_q.pick;
				remaining_q <= alloc_rem;
			end else begin
				status_q    <= fpa_pkg::ST_NOMEM;
				chosen_q    <= '0;
				remaining_q <= '0;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.chosen_index = chosen_q;
	assign rsp.remaining    = remaining_q;

	// at most one token in the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one scan token in the chain");

	// tokens only travel during a scan
	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_v != '0) |-> (state_q == S_SCAN))
		else $error("scan token outside a scan");

	// table writes only when a result is issued
	a_write_at_issue: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> rsp_valid_q && state_q == S_IDLE)
		else $error("table write without a result");

	// not-enough-memory results carry zero fields
	a_nomem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == fpa_pkg::ST_NOMEM) |->
			(chosen_q == '0 && remaining_q == '0))
		else $error("nonzero fields on not-enough-memory result");

endmodule

[rtl/fpa_cell.sv]
// One partition cell: holds its free size, updates the scan token and
// registers it toward the next cell. Depends on fpa_pkg.
module fpa_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpa_pkg::IDX_W-1:0]     cell_idx,
	input  logic [1:0]                    fit_mode,
	input  logic [fpa_pkg::SIZE_BITS-1:0] req_size,
	input  fpa_pkg::wr_t                  wr,
	input  logic                          tok_in_valid,
	input  fpa_pkg::tok_t                 tok_in,
	output logic                          tok_out_valid,
	output fpa_pkg::tok_t                 tok_out
);

	logic [fpa_pkg::SIZE_BITS-1:0] free_q;
	logic [fpa_pkg::SIZE_BITS-1:0] left;
	logic                          fits;
	logic                          take;
	fpa_pkg::tok_t                 tok_nxt;
	fpa_pkg::tok_t                 tok_q;
	logic                          tok_valid_q;

	always_comb begin
		fits = free_q >= req_size;
		left = free_q - req_size;
		case (fit_mode)
			fpa_pkg::MODE_BEST:  take = fits && (!tok_in.found || left < tok_in.key);
			fpa_pkg::MODE_WORST: take = fits && (!tok_in.found || free_q > tok_in.key);
			default:             take = fits && !tok_in.found;
		endcase
		tok_nxt = tok_in;
		if (take) begin
			tok_nxt.found     = 1'b1;
			tok_nxt.pick      = cell_idx;
			tok_nxt.key       = (fit_mode == fpa_pkg::MODE_BEST) ? left : free_q;
			tok_nxt.pick_free = free_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q      <= '0;
			tok_valid_q <= 1'b0;
		end else begin
			if (wr.en && wr.idx == cell_idx) begin
				free_q <= wr.data;
			end
			tok_valid_q <= tok_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
	end

	assign tok_out_valid = tok_valid_q;
	assign tok_out       = tok_q;

endmodule

[verif/fit_policy_partition_allocator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for fit_policy_partition_allocator: directed and random
// load/allocate transactions in every fit mode, checked against a built-in table model.
// Depends on fpa_pkg, fpa_if and the allocator RTL.
module fit_policy_partition_allocator_tb;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int HALF_PERIOD = 2;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 20;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 135;
	localparam int HOLD_TRIGGER = 310;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic                          operation;
		logic [fpa_pkg::IDX_W-1:0]     part_index;
		logic [fpa_pkg::SIZE_BITS-1:0] size;
	} alloc_req_t;

	typedef struct packed {
		logic [1:0]                    status;
		logic [fpa_pkg::IDX_W-1:0]     chosen_index;
		logic [fpa_pkg::SIZE_BITS-1:0] remaining;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;

	fpa_req_if req_bus();
	fpa_rsp_if rsp_bus();
	fpa_cfg_if cfg_bus();

	fit_policy_partition_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	logic [fpa_pkg::SIZE_BITS-1:0] part_free [fpa_pkg::PARTITIONS];
	logic [1:0]                    mode_reg;
	alloc_req_t                    pending_reqs [$];
	alloc_rsp_t                    expected_rsps [$];
	alloc_req_t                    cur_req;
	int                            reqs_open;
	int                            reqs_taken;
	int                            errors;
	int                            cycles;
	int                            snd_gap;
	int                            rcv_gap;
	bit                            req_done;
	bit                            snd_steady;
	bit                            rcv_steady;
	bit                            hold_off;

	always #HALF_PERIOD clk = ~clk;

	function automatic alloc_rsp_t predict_alloc(input alloc_req_t r);
		alloc_rsp_t                    res;
		logic                          hit;
		logic [fpa_pkg::IDX_W-1:0]     pick;
		logic [fpa_pkg::SIZE_BITS-1:0] key;
		if (r.operation == fpa_pkg::OP_LOAD) begin
			part_free[r.part_index] = r.size;
			res.status       = fpa_pkg::ST_LOADED;
			res.chosen_index = r.part_index;
			res.remaining    = r.size;
			return res;
		end
		hit  = 1'b0;
		pick = '0;
		key  = '0;
		for (int k = 0; k < fpa_pkg::PARTITIONS; k++) begin
			if (part_free[k] >= r.size) begin
				if (mode_reg == fpa_pkg::MODE_BEST) begin
					if (!hit || (part_free[k] - r.size) < key) begin
						hit  = 1'b1;
						pick = fpa_pkg::IDX_W'(k);
						key  = part_free[k] - r.size;
					end
				end else if (mode_reg == fpa_pkg::MODE_WORST) begin
					if (!hit || part_free[k] > key) begin
						hit  = 1'b1;
						pick = fpa_pkg::IDX_W'(k);
						key  = part_free[k];
					end
				end else if (!hit) begin
					hit  = 1'b1;
					pick = fpa_pkg::IDX_W'(k);
				end
			end
		end
		if (!hit) begin
			res.status       = fpa_pkg::ST_NOMEM;
			res.chosen_index = '0;
			res.remaining    = '0;
		end else begin
			part_free[pick]  = part_free[pick] - r.size;
			res.status       = fpa_pkg::ST_ALLOC;
			res.chosen_index = pick;
			res.remaining    = part_free[pick];
		end
		return res;
	endfunction

	function automatic int idle_len(input bit steady);
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic alloc_req_t rand_req();
		alloc_req_t r;
		r.operation  = ($urandom_range(0, 99) < 35) ? fpa_pkg::OP_LOAD : fpa_pkg::OP_ALLOC;
		r.part_index = fpa_pkg::IDX_W'($urandom_range(0, fpa_pkg::PARTITIONS - 1));
		case ($urandom_range(0, 9))
			0: r.size = fpa_pkg::SIZE_BITS'($urandom);
			1: r.size = $urandom_range(0, 1) ? '1 : '0;
			default: begin
				if (r.operation == fpa_pkg::OP_LOAD)
					r.size = fpa_pkg::SIZE_BITS'($urandom_range(0, 511));
				else
					r.size = fpa_pkg::SIZE_BITS'($urandom_range(0, 255));
			end
		endcase
		return r;
	endfunction

	task automatic queue_req(input logic op, input int idx, input int sz);
		alloc_req_t r;
		r.operation  = op;
		r.part_index = fpa_pkg::IDX_W'(idx);
		r.size       = fpa_pkg::SIZE_BITS'(sz);
		pending_reqs.push_back(r);
		reqs_open++;
	endtask

	task automatic drain();
		while (reqs_open != 0 || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_fit_mode(input logic [1:0] m);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= m;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		mode_reg = m;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else if (!(req_bus.valid && !req_done)) begin
			if (snd_gap > 0) begin
				snd_gap--;
				req_bus.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				req_bus.operation  <= cur_req.operation;
				req_bus.part_index <= cur_req.part_index;
				req_bus.size       <= cur_req.size;
				req_bus.valid      <= 1'b1;
				snd_gap = idle_len(snd_steady);
			end else begin
				req_bus.valid <= 1'b0;
			end
		end
		req_done = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && req_bus.valid && req_bus.ready) begin
			expected_rsps.push_back(predict_alloc(cur_req));
			reqs_open--;
			reqs_taken++;
			req_done = 1'b1;
		end
	end

	// response ready with random stalls
	always @(negedge clk) begin
		if (!arst_n || hold_off) begin
			rsp_bus.ready <= 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap--;
			rsp_bus.ready <= 1'b0;
		end else begin
			rsp_bus.ready <= 1'b1;
			rcv_gap = idle_len(rcv_steady);
		end
	end

	// response monitor
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected response transaction: status %0d index %0d remaining %0d",
					rsp_bus.status, rsp_bus.chosen_index, rsp_bus.remaining);
				errors++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_bus.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
					errors++;
				end
				if (rsp_bus.chosen_index !== want.chosen_index) begin
					$error("chosen_index: expected %0d, actual %0d",
						want.chosen_index, rsp_bus.chosen_index);
					errors++;
				end
				if (rsp_bus.remaining !== want.remaining) begin
					$error("remaining: expected %0d, actual %0d",
						want.remaining, rsp_bus.remaining);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		hold_off = 1'b0;
		while (reqs_taken < HOLD_TRIGGER)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		logic [1:0] phase_mode;
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_bus.valid      = 1'b0;
		req_bus.operation  = fpa_pkg::OP_LOAD;
		req_bus.part_index = '0;
		req_bus.size       = '0;
		rsp_bus.ready      = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.data       = fpa_pkg::MODE_FIRST;
		mode_reg           = fpa_pkg::MODE_FIRST;
		reqs_open          = 0;
		reqs_taken         = 0;
		errors             = 0;
		cycles             = 0;
		snd_gap            = 0;
		rcv_gap            = 0;
		req_done           = 1'b0;
		snd_steady         = 1'b0;
		rcv_steady         = 1'b0;
		for (int k = 0; k < fpa_pkg::PARTITIONS; k++)
			part_free[k] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		#1 arst_n = 1'b1;

		// empty table under the reset mode: zero request fits, others do not
		queue_req(fpa_pkg::OP_ALLOC, 5, 0);
		queue_req(fpa_pkg::OP_ALLOC, 0, 1);
		queue_req(fpa_pkg::OP_ALLOC, 7, 65535);
		queue_req(fpa_pkg::OP_LOAD, 0, 100);
		queue_req(fpa_pkg::OP_LOAD, 1, 300);
		queue_req(fpa_pkg::OP_LOAD, 2, 200);
		queue_req(fpa_pkg::OP_LOAD, 3, 300);
		queue_req(fpa_pkg::OP_LOAD, 4, 65535);
		queue_req(fpa_pkg::OP_LOAD, 5, 0);
		queue_req(fpa_pkg::OP_LOAD, 6, 150);
		queue_req(fpa_pkg::OP_LOAD, 7, 200);
		queue_req(fpa_pkg::OP_ALLOC, 0, 150);
		drain();
		set_fit_mode(fpa_pkg::MODE_BEST);
		queue_req(fpa_pkg::OP_ALLOC, 3, 150);
		queue_req(fpa_pkg::OP_ALLOC, 0, 0);
		drain();
		set_fit_mode(fpa_pkg::MODE_WORST);
		queue_req(fpa_pkg::OP_ALLOC, 0, 65535);
		queue_req(fpa_pkg::OP_ALLOC, 0, 200);
		queue_req(fpa_pkg::OP_ALLOC, 0, 100);
		queue_req(fpa_pkg::OP_ALLOC, 0, 60000);
		drain();
		set_fit_mode(MODE_SPARE);
		queue_req(fpa_pkg::OP_ALLOC, 0, 100);
		queue_req(fpa_pkg::OP_LOAD, 7, 65535);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: phase_mode = fpa_pkg::MODE_BEST;
				1: phase_mode = fpa_pkg::MODE_WORST;
				2: phase_mode = fpa_pkg::MODE_FIRST;
				3: phase_mode = MODE_SPARE;
				default: phase_mode = 2'($urandom_range(0, 3));
			endcase
			set_fit_mode(phase_mode);
			snd_steady = ($urandom_range(0, 3) == 0);
			rcv_steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pending_reqs.push_back(rand_req());
				reqs_open++;
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
